### rtl/tvcr_pkg.sv
// Shared types and constants for the trajectory view clipping core.
package tvcr_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_VIEW_WIDTH   = 3'd0;
    localparam logic [2:0] REG_VIEW_HEIGHT  = 3'd1;
    localparam logic [2:0] REG_FRAME_LEFT   = 3'd2;
    localparam logic [2:0] REG_FRAME_TOP    = 3'd3;
    localparam logic [2:0] REG_FRAME_RIGHT  = 3'd4;
    localparam logic [2:0] REG_FRAME_BOTTOM = 3'd5;
    localparam logic [2:0] REG_GRID_STEP    = 3'd6;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_PROJ_START,
        ST_PROJ_WAIT,
        ST_SNAP_START,
        ST_SNAP_WAIT,
        ST_DECIDE,
        ST_EMIT0,
        ST_EMIT1
    } seq_state_t;

    // Request from the sequencer to the serial divider.
    typedef struct packed {
        logic start;
        logic dvd_neg;
        logic dvs_neg;
    } div_ctrl_t;

endpackage

### rtl/tvcr_divider.sv
// Radix-2 restoring divider for signed operands, one quotient bit per cycle.
module tvcr_divider
    import tvcr_pkg::*;
#(
    parameter int W = 64
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  div_ctrl_t    ctrl,
    input  logic [W-1:0] dvd_mag,
    input  logic [W-1:0] dvs_mag,
    output logic         done,
    output logic [W:0]   quot,
    output logic [W-1:0] rem
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  q_reg, q_next;
    logic [W-1:0]  dvs_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          neg_reg;
    logic [W:0]    trial;

    // One shift-and-subtract step per cycle.
    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, q_reg[W-1]} - {1'b0, dvs_reg};
        if (ctrl.start)
        begin
            rem_next  = '0;
            q_next    = dvd_mag;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[W])
            begin
                rem_next = trial[W-1:0];
                q_next   = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[W-2:0], q_reg[W-1]};
                q_next   = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (ctrl.start)
        begin
            dvs_reg <= dvs_mag;
            neg_reg <= ctrl.dvd_neg ^ ctrl.dvs_neg;
        end
    end

    // Done pulses on the cycle after the last step.
    logic busy_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_d_reg <= 1'b0;
        else
            busy_d_reg <= busy_reg;
    end

    assign done = busy_d_reg && !busy_reg;
    assign quot = neg_reg ? -{1'b0, q_reg} : {1'b0, q_reg};
    assign rem  = rem_reg;

endmodule

### rtl/tvcr_multiplier.sv
// Serial shift-and-add multiplier for the offset times view size product.
module tvcr_multiplier #(
    parameter int W = 34
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [W-1:0]    a_mag,
    input  logic [12:0]     b,
    output logic            done,
    output logic [W+12:0]   prod
);

    logic [W+12:0] acc_reg;
    logic [W+12:0] a_reg;
    logic [12:0]   b_reg;
    logic [3:0]    cnt_reg;
    logic          busy_reg;

    // One multiplier bit per cycle, least significant first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd13;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == 4'd1)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            a_reg   <= {13'd0, a_mag};
            b_reg   <= b;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_reg <= acc_reg + a_reg;
            a_reg <= {a_reg[W+11:0], 1'b0};
            b_reg <= {1'b0, b_reg[12:1]};
        end
    end

    logic busy_d_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_d_reg <= 1'b0;
        else
            busy_d_reg <= busy_reg;
    end

    assign done = busy_d_reg && !busy_reg;
    assign prod = acc_reg;

endmodule

### rtl/trajectory_view_clip_runs_core.sv
// Top level of the trajectory view clipping core: sequencer, run logic and ports.
//
// Each accepted sample is processed on its own, x axis first, then y. Per axis a serial
// multiplier forms (s - edge) * size, a shared radix-2 divider divides by the frame span
// (48 quotient bits, one per cycle), and the same divider then snaps the result to the
// grid. The input stalls from each transfer until its results are out, so the core takes
// a new sample only when done with the last; output stall holds it longer. An axis with
// a zero frame span skips its snap. Results come as up to two transfers per sample.
module trajectory_view_clip_runs_core
    import tvcr_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] sample_x,
    input  logic [31:0] sample_y,
    input  logic        first_sample,
    input  logic        last_sample,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] point_x,
    output logic [15:0] point_y,
    output logic        point_valid,
    output logic        run_end
);

    // Wide enough for the 47-bit product and for any COORD_BITS up to 48.
    localparam int DW = 48;
    localparam int MW = 34;

    // Configuration registers.
    logic [12:0] vw_reg, vh_reg;
    logic [31:0] fl_reg, ft_reg, fr_reg, fb_reg;
    logic [7:0]  gs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg <= 13'd400;
            vh_reg <= 13'd400;
            fl_reg <= '0;
            ft_reg <= '0;
            fr_reg <= 32'd400;
            fb_reg <= 32'd400;
            gs_reg <= 8'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIEW_WIDTH:   vw_reg <= cfg_data[12:0];
                REG_VIEW_HEIGHT:  vh_reg <= cfg_data[12:0];
                REG_FRAME_LEFT:   fl_reg <= cfg_data;
                REG_FRAME_TOP:    ft_reg <= cfg_data;
                REG_FRAME_RIGHT:  fr_reg <= cfg_data;
                REG_FRAME_BOTTOM: fb_reg <= cfg_data;
                REG_GRID_STEP:    gs_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Sample capture and state.
    seq_state_t state_reg, state_next;
    logic [31:0] sx_reg, sy_reg;
    logic        last_reg;
    logic        axis_reg;
    logic [COORD_BITS-1:0] nx_reg, ny_reg, px_reg, py_reg;
    logic        pv_reg, ir_reg;
    logic [DW-1:0] q_reg;
    logic        zero_reg;
    logic [1:0]  nres_reg;
    logic [15:0] ox0_reg, oy0_reg, ox1_reg, oy1_reg;
    logic [1:0]  ofl0_reg, ofl1_reg;

    // Axis operands.
    logic signed [32:0] s_ax, lo_ax, hi_ax;
    logic [12:0]        size_ax;
    logic signed [33:0] off, den;
    logic [MW-1:0]      off_mag;

    assign s_ax    = axis_reg ? {sy_reg[31], sy_reg} : {sx_reg[31], sx_reg};
    assign lo_ax   = axis_reg ? {ft_reg[31], ft_reg} : {fl_reg[31], fl_reg};
    assign hi_ax   = axis_reg ? {fb_reg[31], fb_reg} : {fr_reg[31], fr_reg};
    assign size_ax = axis_reg ? vh_reg : vw_reg;
    assign off     = {s_ax[32], s_ax} - {lo_ax[32], lo_ax};
    assign den     = {hi_ax[32], hi_ax} - {lo_ax[32], lo_ax};
    assign off_mag = off[33] ? MW'(-off) : MW'(off);

    // Serial multiplier, started once per axis.
    logic           mstart;
    logic           mdone;
    logic [MW+12:0] prod;

    assign mstart = (state_reg == ST_MUL_START);

    tvcr_multiplier #(.W(MW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .a_mag (off_mag),
        .b     (size_ax),
        .done  (mdone),
        .prod  (prod)
    );

    // Shared divider.
    div_ctrl_t     dctrl;
    logic [DW-1:0] dvd_mag, dvs_mag;
    logic          ddone;
    logic [DW:0]   quot;
    logic [DW-1:0] drem;
    logic [7:0]    g_eff;
    logic signed [DW-1:0] cmin, cmax;
    logic signed [DW:0]   q_sat_in;
    logic [COORD_BITS-1:0] snapped;
    logic [DW-1:0] snap_full;

    assign g_eff = (gs_reg == 8'd0) ? 8'd1 : gs_reg;
    assign cmin  = -(DW'(1) <<< (COORD_BITS - 1));
    assign cmax  = (DW'(1) <<< (COORD_BITS - 1)) - DW'(1);

    tvcr_divider #(.W(DW)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (dctrl),
        .dvd_mag (dvd_mag),
        .dvs_mag (dvs_mag),
        .done    (ddone),
        .quot    (quot),
        .rem     (drem)
    );

    // Snapping removes the remainder, which carries the sign of the quotient.
    assign q_sat_in  = quot;
    assign snap_full = q_reg[DW-1] ? q_reg + drem : q_reg - drem;
    assign snapped   = COORD_BITS'(snap_full);

    // Divider operand selection.
    always_comb
    begin
        dctrl   = '0;
        dvd_mag = '0;
        dvs_mag = '0;
        if (state_reg == ST_PROJ_START)
        begin
            dctrl.start   = 1'b1;
            dctrl.dvd_neg = off[33];
            dctrl.dvs_neg = den[33];
            dvd_mag = DW'(prod);
            dvs_mag = den[33] ? DW'(-den) : DW'(den);
        end
        else if (state_reg == ST_SNAP_START)
        begin
            dctrl.start   = 1'b1;
            dctrl.dvd_neg = q_reg[DW-1];
            dvd_mag = q_reg[DW-1] ? -q_reg : q_reg;
            dvs_mag = DW'(g_eff);
        end
    end

    // Inside test and emission on the mapped point.
    logic signed [COORD_BITS-1:0] nxs, nys;
    logic in_view, same;
    assign nxs     = nx_reg;
    assign nys     = ny_reg;
    assign in_view = !nxs[COORD_BITS-1] && !nys[COORD_BITS-1] &&
                     (nx_reg < COORD_BITS'(vw_reg)) && (ny_reg < COORD_BITS'(vh_reg));
    assign same    = (nx_reg == px_reg) && (ny_reg == py_reg);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:       if (in_valid) state_next = ST_MUL_START;
            ST_MUL_START:  state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:   if (mdone) state_next = ST_PROJ_START;
            ST_PROJ_START: state_next = ST_PROJ_WAIT;
            ST_PROJ_WAIT:
            begin
                if (ddone)
                begin
                    if (!zero_reg)
                        state_next = ST_SNAP_START;
                    else
                        state_next = axis_reg ? ST_DECIDE : ST_MUL_START;
                end
            end
            ST_SNAP_START: state_next = ST_SNAP_WAIT;
            ST_SNAP_WAIT:  if (ddone) state_next = axis_reg ? ST_DECIDE : ST_MUL_START;
            ST_DECIDE:     state_next = ST_EMIT0;
            ST_EMIT0:
            begin
                if (nres_reg == 2'd0)
                    state_next = ST_IDLE;
                else if (!out_stall)
                    state_next = (nres_reg == 2'd2) ? ST_EMIT1 : ST_IDLE;
            end
            ST_EMIT1:      if (!out_stall) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Results caused by the mapped point and the run state.
    logic [1:0] n;
    logic [15:0] ex0, ey0, ex1, ey1;
    logic [1:0]  f0, f1;
    logic        ir_new;

    always_comb
    begin
        n   = 2'd0;
        ex0 = '0; ey0 = '0; ex1 = '0; ey1 = '0;
        f0  = '0; f1  = '0;
        ir_new = ir_reg;
        if (in_view)
        begin
            if (pv_reg && !ir_reg)
            begin
                ex0 = px_reg[15:0]; ey0 = py_reg[15:0]; f0 = 2'b10;
                n = 2'd1;
            end
            if (!pv_reg || !same)
            begin
                if (n == 2'd0)
                begin
                    ex0 = nx_reg[15:0]; ey0 = ny_reg[15:0]; f0 = 2'b10;
                end
                else
                begin
                    ex1 = nx_reg[15:0]; ey1 = ny_reg[15:0]; f1 = 2'b10;
                end
                n = n + 2'd1;
            end
            ir_new = 1'b1;
        end
        else
        begin
            if (ir_reg)
            begin
                ex0 = nx_reg[15:0]; ey0 = ny_reg[15:0]; f0 = 2'b11;
                n = 2'd1;
            end
            ir_new = 1'b0;
        end
        if (last_reg && ir_new)
        begin
            if (n == 2'd0)
            begin
                f0 = 2'b01;
                n  = 2'd1;
            end
            else if (n == 2'd1)
                f0[0] = 1'b1;
            else
                f1[0] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pv_reg     <= 1'b0;
            ir_reg     <= 1'b0;
            nres_reg   <= '0;
        end
        else
        begin
            if (state_reg == ST_IDLE && in_valid && first_sample)
            begin
                pv_reg <= 1'b0;
                ir_reg <= 1'b0;
            end
            if (state_reg == ST_DECIDE)
            begin
                nres_reg <= n;
                pv_reg   <= !last_reg;
                ir_reg   <= ir_new && !last_reg;
            end
            if (state_reg == ST_EMIT0 && nres_reg == 2'd1 && !out_stall)
                nres_reg <= '0;
        end
    end

    // Capture the sample and collect the mapped coordinates.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            sx_reg   <= sample_x;
            sy_reg   <= sample_y;
            last_reg <= last_sample;
            axis_reg <= 1'b0;
        end
        if (state_reg == ST_PROJ_START)
            zero_reg <= (den == '0);
        if (state_reg == ST_PROJ_WAIT && ddone)
        begin
            if (zero_reg)
                q_reg <= cmin;
            else if (q_sat_in < cmin)
                q_reg <= cmin;
            else if (q_sat_in > cmax)
                q_reg <= cmax;
            else
                q_reg <= DW'(q_sat_in);
            if (zero_reg)
            begin
                if (axis_reg)
                    ny_reg <= COORD_BITS'(cmin);
                else
                    nx_reg <= COORD_BITS'(cmin);
                axis_reg <= 1'b1;
            end
        end
        if (state_reg == ST_SNAP_WAIT && ddone)
        begin
            if (axis_reg)
                ny_reg <= snapped;
            else
                nx_reg <= snapped;
            axis_reg <= 1'b1;
        end
        if (state_reg == ST_DECIDE)
        begin
            px_reg  <= nx_reg;
            py_reg  <= ny_reg;
            ox0_reg <= ex0; oy0_reg <= ey0; ofl0_reg <= f0;
            ox1_reg <= ex1; oy1_reg <= ey1; ofl1_reg <= f1;
        end
    end

    assign in_stall    = (state_reg != ST_IDLE);
    assign out_valid   = (state_reg == ST_EMIT0 && nres_reg != 2'd0) ||
                         (state_reg == ST_EMIT1);
    assign point_x     = (state_reg == ST_EMIT1) ? ox1_reg : ox0_reg;
    assign point_y     = (state_reg == ST_EMIT1) ? oy1_reg : oy0_reg;
    assign point_valid = (state_reg == ST_EMIT1) ? ofl1_reg[1] : ofl0_reg[1];
    assign run_end     = (state_reg == ST_EMIT1) ? ofl1_reg[0] : ofl0_reg[0];

endmodule

### sim/tb_top.sv
// Self-checking testbench for the trajectory view clipping core.
module tb_top;
    import tvcr_pkg::*;

    // One emitted point or run-end marker.
    typedef struct {
        logic [15:0] px;
        logic [15:0] py;
        logic        pv;
        logic        re;
    } clip_point_t;

    // Clip predictor with its own copy of the registers and the run state.
    class clip_scoreboard;
        int unsigned view_w, view_h, grid;
        longint      f_left, f_top, f_right, f_bottom;
        longint      last_x, last_y;
        bit          have_last, in_run;
        clip_point_t due[$];
        int          errors;
        int          n_points;
        int          n_markers;

        function void reset_all();
            view_w = 400; view_h = 400; grid = 1;
            f_left = 0; f_top = 0; f_right = 400; f_bottom = 400;
            last_x = 0; last_y = 0; have_last = 0; in_run = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] v);
            case (idx)
                REG_VIEW_WIDTH:   view_w = v[12:0];
                REG_VIEW_HEIGHT:  view_h = v[12:0];
                REG_FRAME_LEFT:   f_left = $signed(v);
                REG_FRAME_TOP:    f_top = $signed(v);
                REG_FRAME_RIGHT:  f_right = $signed(v);
                REG_FRAME_BOTTOM: f_bottom = $signed(v);
                REG_GRID_STEP:    grid = v[7:0];
                default: ;
            endcase
        endfunction

        // Project one axis into pixels and snap to the grid.
        function longint project(longint s, longint lo, longint hi, longint size);
            longint den, q, g;
            den = hi - lo;
            g = (grid != 0) ? grid : 1;
            if (den == 0)
                return -64'sd2147483648;
            q = ((s - lo) * size) / den;
            if (q < -64'sd2147483648)
                q = -64'sd2147483648;
            if (q > 64'sd2147483647)
                q = 64'sd2147483647;
            return q / g * g;
        endfunction

        function void push_point(longint x, longint y, bit pv, bit re);
            clip_point_t p;
            p.px = x[15:0];
            p.py = y[15:0];
            p.pv = pv;
            p.re = re;
            due.push_back(p);
        endfunction

        // Note an accepted sample and queue the points it causes.
        function void note_input(logic [31:0] sx, logic [31:0] sy, logic f, logic l);
            longint nx, ny;
            bit in_view;
            int n;
            n = 0;
            if (f)
            begin
                have_last = 0;
                in_run = 0;
            end
            nx = project($signed(sx), f_left, f_right, view_w);
            ny = project($signed(sy), f_top, f_bottom, view_h);
            in_view = nx >= 0 && nx < view_w && ny >= 0 && ny < view_h;
            if (in_view)
            begin
                if (have_last && !in_run)
                begin
                    push_point(last_x, last_y, 1, 0);
                    n++;
                end
                if (!have_last || nx != last_x || ny != last_y)
                begin
                    push_point(nx, ny, 1, 0);
                    n++;
                end
                in_run = 1;
            end
            else
            begin
                if (in_run)
                begin
                    push_point(nx, ny, 1, 1);
                    n++;
                end
                in_run = 0;
            end
            last_x = nx;
            last_y = ny;
            have_last = 1;
            if (l)
            begin
                if (in_run)
                begin
                    if (n > 0)
                        due[due.size() - 1].re = 1;
                    else
                        push_point(0, 0, 0, 1);
                end
                have_last = 0;
                in_run = 0;
            end
        endfunction

        // Compare one received transfer with the oldest queued point.
        function void check(clip_point_t got);
            clip_point_t want;
            if (due.size() == 0)
            begin
                $error("unexpected output transfer x=%h y=%h", got.px, got.py);
                errors++;
                return;
            end
            want = due.pop_front();
            if (got.pv) n_points++; else n_markers++;
            if (got.px !== want.px)
            begin
                $error("point_x: expected %h, got %h", want.px, got.px);
                errors++;
            end
            if (got.py !== want.py)
            begin
                $error("point_y: expected %h, got %h", want.py, got.py);
                errors++;
            end
            if (got.pv !== want.pv)
            begin
                $error("point_valid: expected %b, got %b", want.pv, got.pv);
                errors++;
            end
            if (got.re !== want.re)
            begin
                $error("run_end: expected %b, got %b", want.re, got.re);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 0;
    logic        rst_n = 0;
    logic        cfg_we = 0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic        in_valid = 0;
    logic        in_stall;
    logic [31:0] sample_x = '0;
    logic [31:0] sample_y = '0;
    logic        first_sample = 0;
    logic        last_sample = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [15:0] point_x;
    logic [15:0] point_y;
    logic        point_valid;
    logic        run_end;

    clip_scoreboard sb = new();
    int unsigned    idle_pct = 0;
    int unsigned    stall_pct = 0;
    int             sent_count = 0;
    int             n_configs = 0;
    logic [31:0]    prev_sx = '0;
    logic [31:0]    prev_sy = '0;

    trajectory_view_clip_runs_core DUT (.*);

    always #5 clk = ~clk;

    // Receiver: random stall at the falling edge, check at the rising edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin
        clip_point_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.px = point_x;
            got.py = point_y;
            got.pv = point_valid;
            got.re = run_end;
            sb.check(got);
        end
    end

    // Idling mode: none, sender idle, receiver stalling, both.
    task automatic set_mode(int m);
        case (m % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 67; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 67; end
            default: begin idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    // One sample transfer; valid stays high if the next follows at once.
    task automatic send(logic [31:0] x, logic [31:0] y, logic f, logic l);
        if ($urandom_range(99) < idle_pct)
        begin
            in_valid = 0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        sample_x = x;
        sample_y = y;
        first_sample = f;
        last_sample = l;
        in_valid = 1;
        do @(posedge clk); while (in_stall);
        sb.note_input(x, y, f, l);
        sent_count++;
        prev_sx = x;
        prev_sy = y;
        @(negedge clk);
    endtask

    // Wait until every queued point has arrived and the core has settled.
    task automatic drain();
        in_valid = 0;
        while (sb.due.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] v);
        cfg_we = 1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_we = 0;
        sb.set_reg(idx, v);
    endtask

    task automatic set_view(int unsigned w, int unsigned h, longint l, longint t,
                            longint r, longint b, int unsigned g);
        write_reg(REG_VIEW_WIDTH, w);
        write_reg(REG_VIEW_HEIGHT, h);
        write_reg(REG_FRAME_LEFT, l[31:0]);
        write_reg(REG_FRAME_TOP, t[31:0]);
        write_reg(REG_FRAME_RIGHT, r[31:0]);
        write_reg(REG_FRAME_BOTTOM, b[31:0]);
        write_reg(REG_GRID_STEP, g);
        n_configs++;
    endtask

    // Coordinate mostly around the frame so runs enter and leave the view.
    function automatic logic [31:0] pick_coord(longint lo, longint hi);
        longint a, w, v;
        a = (lo < hi) ? lo : hi;
        w = (lo < hi) ? hi - lo : lo - hi;
        if ($urandom_range(7) == 0 || w > 64'sd2000000000)
            return $urandom;
        v = a - w / 4 + ($urandom % (w + w / 2 + 5)) - 2;
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // Random trajectories; some samples repeat, some markers are scrambled.
    task automatic random_trajectories(int items);
        int left, len, i;
        logic f, l;
        logic [31:0] x, y;
        left = items;
        while (left > 0)
        begin
            len = $urandom_range(1, 9);
            for (i = 0; i < len && left > 0; i++)
            begin
                f = (i == 0);
                l = (i == len - 1);
                if ($urandom_range(9) == 0) f = 1'($urandom_range(1));
                if ($urandom_range(9) == 0) l = 1'($urandom_range(1));
                if (i > 0 && $urandom_range(5) == 0)
                begin
                    x = prev_sx;
                    y = prev_sy;
                end
                else
                begin
                    x = pick_coord(sb.f_left, sb.f_right);
                    y = pick_coord(sb.f_top, sb.f_bottom);
                end
                if (left % 100 == 0) set_mode(left / 100);
                send(x, y, f, l);
                left--;
            end
        end
        drain();
    endtask

    initial
    begin
        sb.reset_all();
        repeat (9) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // Directed: runs entering, leaving, repeats and closing markers.
        send(32'd0, 32'd0, 1, 0);
        send(32'd399, 32'd399, 0, 0);
        send(32'd399, 32'd399, 0, 0);
        send(32'd400, 32'd0, 0, 0);
        send(-32'sd1, -32'sd1, 0, 0);
        send(32'd10, 32'd10, 0, 1);
        send(32'd5, 32'd5, 1, 1);
        send(32'd500, 32'd5, 1, 1);
        send(32'd5, 32'd5, 1, 0);
        send(32'd5, 32'd5, 0, 1);
        send(32'h80000000, 32'h7fffffff, 1, 0);
        send(32'h7fffffff, 32'h80000000, 0, 0);
        send(32'd200, 32'd100, 0, 0);
        send(32'h80000000, 32'd100, 0, 1);
        drain();

        // Wide frame, a 4096-pixel view and the largest grid step.
        set_view(4096, 4096, -64'sd2147483648, -64'sd2147483648,
                 64'sd2147483647, 64'sd2147483647, 255);
        send(32'h80000000, 32'h80000000, 1, 0);
        send(32'h7fffffff, 32'h7fffffff, 0, 0);
        send(32'h00000000, 32'h00000000, 0, 1);
        drain();

        // Zero span on x, single-pixel view.
        set_view(1, 1, 100, 0, 100, 10, 1);
        send(32'd100, 32'd0, 1, 0);
        send(32'd100, 32'd5, 0, 1);
        drain();

        // Zero grid step and zero view size.
        set_view(0, 0, 0, 0, 400, 400, 0);
        send(32'd1, 32'd1, 1, 1);
        drain();

        // Random phases through several settings.
        set_view(400, 400, 0, 0, 400, 400, 1);
        random_trajectories(450);
        set_view(640, 480, 1000, -500, -1000, 500, 7);
        random_trajectories(350);
        set_view(4096, 3, -64'sd2147483648, 0, 64'sd2147483647, 30, 255);
        random_trajectories(250);
        set_view(37, 4096, -20, 50, 20, 5000, 16);
        random_trajectories(350);
        set_view(4096, 4096, 0, 0, 64, 64, 1);
        random_trajectories(300);
        set_view(1, 2, 0, 0, 1, 2, 0);
        random_trajectories(50);

        $display("Covered %0d samples over %0d view settings and four idling modes.",
                 sent_count, n_configs);
        $display("Checked %0d points and %0d bare run-end markers.",
                 sb.n_points, sb.n_markers);
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

    // Watchdog for a hung core.
    initial
    begin
        #60000000;
        $display("tb_top failed");
        $finish;
    end
endmodule
